@@ hw/rtl/lob_pkg.sv @@
// ----------------------------------------------------------------------------
// lob_pkg
// Types, sizes and sequencer operation codes of the order book matcher.
// ----------------------------------------------------------------------------
`default_nettype none
package lob_pkg;
  localparam int PRICE_LEVELS = 256;
  localparam int ORDER_IDS = 64;
  localparam int IdW = 6;
  localparam int LinkW = 7;
  localparam int PriceW = 8;
  localparam int LvlW = 9;
  localparam int QtyW = 32;
  localparam logic [LinkW-1:0] NIL_ID = 7'd64;

  typedef struct packed {
    logic              mode;
    logic [IdW-1:0]    ord_id;
    logic              side;
    logic [PriceW-1:0] limit_price;
    logic [QtyW-1:0]   order_quantity;
  } in_word_t;

  typedef struct packed {
    logic [IdW-1:0]    maker_id;
    logic [IdW-1:0]    taker_id;
    logic [PriceW-1:0] trade_price;
    logic [QtyW-1:0]   trade_quantity;
    logic              last;
  } out_word_t;

  typedef enum logic [4:0] {
    OP_CLR, OP_IDLE, OP_CHECK, OP_CXL, OP_UNLINK, OP_MTEST, OP_HEAD, OP_SWEEP,
    OP_FILL, OP_LCHK, OP_LEMP, OP_ADV, OP_SKIP, OP_SKCHK, OP_FIN, OP_APRD,
    OP_APWR, OP_APLNK, OP_EMIT
  } op_e;

  typedef struct packed {
    logic clr_done;
    logic is_cancel;
    logic reject;
    logic qty_zero;
    logic can_match;
    logic r_nil;
    logic head_nil;
    logic skip_in;
    logic full_fill;
    logic slot_ok;
  } st_t;
endpackage
`default_nettype wire

@@ hw/rtl/lob_in_if.sv @@
// ----------------------------------------------------------------------------
// lob_in_if
// Order channel: valid, ready and one order word.
// ----------------------------------------------------------------------------
`default_nettype none
interface lob_in_if;
  import lob_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lob_out_if.sv @@
// ----------------------------------------------------------------------------
// lob_out_if
// Trade channel: valid, ready and one trade word.
// ----------------------------------------------------------------------------
`default_nettype none
interface lob_out_if;
  import lob_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lob_ctrl.sv @@
// ----------------------------------------------------------------------------
// lob_ctrl
// Sequencer of the matcher: steps through check, match, unlink and rest.
// ----------------------------------------------------------------------------
`default_nettype none
module lob_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire lob_pkg::st_t st_i,
  output lob_pkg::op_e     op_o
);
  import lob_pkg::*;

  localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_CHECK = 5'd2, S_CXL = 5'd3,
    S_UNLINK = 5'd4, S_MTEST = 5'd5, S_HEAD = 5'd6, S_SWEEP = 5'd7, S_FILL = 5'd8,
    S_LCHK = 5'd9, S_LEMP = 5'd10, S_ADV = 5'd11, S_SKIP = 5'd12, S_SKCHK = 5'd13,
    S_FIN = 5'd14, S_APRD = 5'd15, S_APWR = 5'd16, S_APLNK = 5'd17, S_EMIT = 5'd18;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o = OP_IDLE;
    unique case (state_q)
      S_CLR: begin
        op_o = OP_CLR;
        if (st_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        op_o = OP_IDLE;
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        op_o = OP_CHECK;
        if (st_i.reject) state_d = S_IDLE;
        else if (st_i.is_cancel) state_d = S_CXL;
        else state_d = S_MTEST;
      end
      S_CXL: begin
        op_o = OP_CXL;
        state_d = S_UNLINK;
      end
      S_UNLINK: begin
        op_o = OP_UNLINK;
        state_d = st_i.is_cancel ? S_IDLE : S_SWEEP;
      end
      S_MTEST: begin
        op_o = OP_MTEST;
        state_d = (st_i.can_match && !st_i.qty_zero) ? S_HEAD : S_FIN;
      end
      S_HEAD: begin
        op_o = OP_HEAD;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        op_o = OP_SWEEP;
        state_d = (!st_i.r_nil && !st_i.qty_zero) ? S_FILL : S_LCHK;
      end
      S_FILL: begin
        op_o = OP_FILL;
        if (st_i.slot_ok) state_d = st_i.full_fill ? S_UNLINK : S_SWEEP;
      end
      S_LCHK: begin
        op_o = OP_LCHK;
        state_d = S_LEMP;
      end
      S_LEMP: begin
        op_o = OP_LEMP;
        state_d = st_i.head_nil ? S_ADV : S_MTEST;
      end
      S_ADV: begin
        op_o = OP_ADV;
        state_d = S_SKIP;
      end
      S_SKIP: begin
        op_o = OP_SKIP;
        state_d = st_i.skip_in ? S_SKCHK : S_MTEST;
      end
      S_SKCHK: begin
        op_o = OP_SKCHK;
        state_d = st_i.head_nil ? S_ADV : S_MTEST;
      end
      S_FIN: begin
        op_o = OP_FIN;
        state_d = st_i.qty_zero ? S_EMIT : S_APRD;
      end
      S_APRD: begin
        op_o = OP_APRD;
        state_d = S_APWR;
      end
      S_APWR: begin
        op_o = OP_APWR;
        state_d = S_APLNK;
      end
      S_APLNK: begin
        op_o = OP_APLNK;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        op_o = OP_EMIT;
        if (st_i.slot_ok) state_d = S_IDLE;
      end
      default: begin
        op_o = OP_IDLE;
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLR;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

@@ hw/rtl/lob_dp.sv @@
// ----------------------------------------------------------------------------
// lob_dp
// Book memories, order registers, best prices and the trade output stage.
// ----------------------------------------------------------------------------
`default_nettype none
module lob_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lob_pkg::op_e     op_i,
  input  wire logic             in_accept_i,
  input  wire lob_pkg::in_word_t in_data_i,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output lob_pkg::out_word_t    out_data_o,
  output lob_pkg::st_t          st_o
);
  import lob_pkg::*;

  logic [LinkW-1:0]  head_mem [2*PRICE_LEVELS];
  logic [LinkW-1:0]  tail_mem [2*PRICE_LEVELS];
  logic [LinkW-1:0]  nxt_mem  [ORDER_IDS];
  logic [LinkW-1:0]  prv_mem  [ORDER_IDS];
  logic [QtyW-1:0]   qty_mem  [ORDER_IDS];
  logic [LvlW-1:0]   ps_mem   [ORDER_IDS];

  logic [LinkW-1:0]  head_rd_q, tail_rd_q, nxt_rd_q, prv_rd_q;
  logic [QtyW-1:0]   qty_rd_q;
  logic [LvlW-1:0]   ps_rd_q;

  logic [ORDER_IDS-1:0] valid_q;
  logic [PriceW-1:0] best_bid_q;
  logic [LvlW-1:0]   best_ask_q;
  logic [LvlW-1:0]   clr_q;
  logic              out_v_q, pend_v_q;
  out_word_t         out_q, pend_q;

  logic              mode_q, side_q;
  logic [IdW-1:0]    id_q;
  logic [PriceW-1:0] price_q;
  logic [QtyW-1:0]   qty_q;
  logic [LinkW-1:0]  r_q, u_p_q, u_n_q;
  logic [LvlW-1:0]   lvl_q;

  logic [LvlW-1:0]   best_lvl, hd_raddr, own_lvl;
  logic [IdW-1:0]    id_raddr;
  logic [QtyW-1:0]   fill;
  logic              out_free, slot_ok, move, full_fill, can_match;

  logic              hd_we, tl_we, nx_we, pv_we, qm_we, ps_we;
  logic [LvlW-1:0]   hd_wa, tl_wa;
  logic [IdW-1:0]    nx_wa, pv_wa, qm_wa;
  logic [LinkW-1:0]  hd_wd, tl_wd, nx_wd, pv_wd;
  logic [QtyW-1:0]   qm_wd;

  assign own_lvl   = {side_q, price_q};
  assign best_lvl  = side_q ? {1'b0, best_bid_q} : {1'b1, best_ask_q[PriceW-1:0]};
  assign fill      = (qty_q < qty_rd_q) ? qty_q : qty_rd_q;
  assign full_fill = (qty_rd_q <= qty_q);
  assign out_free  = !out_v_q || out_ready_i;
  assign slot_ok   = !pend_v_q || out_free;
  assign move      = pend_v_q && out_free && ((op_i == OP_FILL) || (op_i == OP_EMIT));
  assign can_match = side_q ? ((best_bid_q >= price_q) && (best_bid_q != '0))
                            : ((best_ask_q <= {1'b0, price_q}) && !best_ask_q[LvlW-1]);

  always_comb begin
    hd_raddr = best_lvl;
    if (op_i == OP_LCHK) hd_raddr = lvl_q;
    else if (op_i == OP_APRD) hd_raddr = own_lvl;
    id_raddr = (op_i == OP_CHECK) ? id_q : r_q[IdW-1:0];
  end

  always_comb begin
    st_o.clr_done  = (clr_q == '1);
    st_o.is_cancel = mode_q;
    st_o.reject    = mode_q ? !valid_q[id_q]
                            : ((price_q == '0) || (qty_q == '0) || valid_q[id_q]);
    st_o.qty_zero  = (qty_q == '0);
    st_o.can_match = can_match;
    st_o.r_nil     = (r_q == NIL_ID);
    st_o.head_nil  = (head_rd_q == NIL_ID);
    st_o.skip_in   = side_q ? (best_bid_q != '0) : !best_ask_q[LvlW-1];
    st_o.full_fill = full_fill;
    st_o.slot_ok   = slot_ok;
  end

  always_comb begin
    hd_we = 1'b0; hd_wa = lvl_q; hd_wd = u_n_q;
    tl_we = 1'b0; tl_wa = lvl_q; tl_wd = u_p_q;
    nx_we = 1'b0; nx_wa = u_p_q[IdW-1:0]; nx_wd = u_n_q;
    pv_we = 1'b0; pv_wa = u_n_q[IdW-1:0]; pv_wd = u_p_q;
    qm_we = 1'b0; qm_wa = r_q[IdW-1:0]; qm_wd = qty_rd_q - fill;
    ps_we = 1'b0;
    case (op_i)
      OP_CLR: begin
        hd_we = 1'b1; hd_wa = clr_q; hd_wd = NIL_ID;
        tl_we = 1'b1; tl_wa = clr_q; tl_wd = NIL_ID;
      end
      OP_UNLINK: begin
        hd_we = (u_p_q == NIL_ID);
        nx_we = (u_p_q != NIL_ID);
        tl_we = (u_n_q == NIL_ID);
        pv_we = (u_n_q != NIL_ID);
      end
      OP_FILL: qm_we = slot_ok;
      OP_APWR: begin
        hd_we = (tail_rd_q == NIL_ID); hd_wa = own_lvl; hd_wd = {1'b0, id_q};
        tl_we = 1'b1; tl_wa = own_lvl; tl_wd = {1'b0, id_q};
        nx_we = 1'b1; nx_wa = id_q; nx_wd = NIL_ID;
        pv_we = 1'b1; pv_wa = id_q; pv_wd = tail_rd_q;
        qm_we = 1'b1; qm_wa = id_q; qm_wd = qty_q;
        ps_we = 1'b1;
      end
      OP_APLNK: begin
        nx_we = (u_p_q != NIL_ID); nx_wd = {1'b0, id_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hd_we) head_mem[hd_wa] <= hd_wd;
    if (tl_we) tail_mem[tl_wa] <= tl_wd;
    if (nx_we) nxt_mem[nx_wa] <= nx_wd;
    if (pv_we) prv_mem[pv_wa] <= pv_wd;
    if (qm_we) qty_mem[qm_wa] <= qm_wd;
    if (ps_we) ps_mem[id_q] <= own_lvl;
    head_rd_q <= head_mem[hd_raddr];
    tail_rd_q <= tail_mem[hd_raddr];
    nxt_rd_q  <= nxt_mem[id_raddr];
    prv_rd_q  <= prv_mem[id_raddr];
    qty_rd_q  <= qty_mem[id_raddr];
    ps_rd_q   <= ps_mem[id_raddr];
  end

  // order registers and trade words
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      mode_q  <= in_data_i.mode;
      id_q    <= in_data_i.ord_id;
      side_q  <= in_data_i.side;
      price_q <= in_data_i.limit_price;
      qty_q   <= in_data_i.order_quantity;
    end
    case (op_i)
      OP_CXL: begin
        lvl_q <= ps_rd_q;
        u_p_q <= prv_rd_q;
        u_n_q <= nxt_rd_q;
      end
      OP_MTEST: lvl_q <= best_lvl;
      OP_HEAD: r_q <= head_rd_q;
      OP_FILL: begin
        if (slot_ok) begin
          pend_q.maker_id       <= r_q[IdW-1:0];
          pend_q.taker_id       <= id_q;
          pend_q.trade_price    <= ps_rd_q[PriceW-1:0];
          pend_q.trade_quantity <= fill;
          pend_q.last           <= 1'b0;
          qty_q <= qty_q - fill;
          r_q   <= nxt_rd_q;
          u_p_q <= prv_rd_q;
          u_n_q <= nxt_rd_q;
        end
      end
      OP_APWR: u_p_q <= tail_rd_q;
      default: ;
    endcase
    if (move) begin
      out_q.maker_id       <= pend_q.maker_id;
      out_q.taker_id       <= pend_q.taker_id;
      out_q.trade_price    <= pend_q.trade_price;
      out_q.trade_quantity <= pend_q.trade_quantity;
      out_q.last           <= (op_i == OP_EMIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      best_bid_q <= '0;
      best_ask_q <= LvlW'(PRICE_LEVELS);
      clr_q      <= '0;
      out_v_q    <= 1'b0;
      pend_v_q   <= 1'b0;
    end else begin
      if (op_i == OP_CLR && clr_q != '1) clr_q <= clr_q + 1'b1;
      case (op_i)
        OP_CXL: valid_q[id_q] <= 1'b0;
        OP_FILL: begin
          if (slot_ok) begin
            pend_v_q <= 1'b1;
            if (full_fill) valid_q[r_q[IdW-1:0]] <= 1'b0;
          end
        end
        OP_ADV: begin
          if (side_q) best_bid_q <= best_bid_q - 1'b1;
          else best_ask_q <= best_ask_q + 1'b1;
        end
        OP_APWR: begin
          valid_q[id_q] <= 1'b1;
          if (!side_q && price_q > best_bid_q) best_bid_q <= price_q;
          if (side_q && {1'b0, price_q} < best_ask_q) best_ask_q <= {1'b0, price_q};
        end
        OP_EMIT: if (slot_ok) pend_v_q <= 1'b0;
        default: ;
      endcase
      if (move) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

@@ hw/rtl/limit_order_book_matcher_core.sv @@
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core
// Price-time priority order book: takes add and cancel words, emits trades.
// ----------------------------------------------------------------------------
// in_i takes one order word at a time (add or cancel); out_o delivers one
// trade word per fill, with last set on the final trade of an add.
// After reset the block runs a clearing pass over all 512 level entries
// of the head and tail memories; in_i.ready stays low until it ends.
// A rejected add, an unknown cancel and a cancel give no trade. An add
// walks the resting orders of the opposite side from the best price,
// level by level and in time order, and the best-price search steps over
// emptied or empty price levels; a remainder is then rested in the book.
// Trades leave through an output register fed by a one-word hold stage;
// when the receiver stalls, matching waits at the next fill and no trade
// is lost. A new order is taken only after the previous one has finished.
// ----------------------------------------------------------------------------
`default_nettype none
module limit_order_book_matcher_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lob_in_if.sink    in_i,
  lob_out_if.source out_o
);
  import lob_pkg::*;

  op_e       op;
  st_t       st;
  logic      out_valid;
  out_word_t out_data;

  assign in_i.ready = (op == OP_IDLE);
  assign out_o.valid = out_valid;
  assign out_o.data = out_data;

  lob_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .st_i       (st),
    .op_o       (op)
  );

  lob_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .in_accept_i (in_i.valid && (op == OP_IDLE)),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .st_o        (st)
  );
endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives order words into the order book matcher and checks every trade word
// against a price-time priority book kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import lob_pkg::*;

  localparam int NIL = 64;
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_CXL = 1'b1;
  localparam logic SIDE_BUY = 1'b0;
  localparam logic SIDE_SELL = 1'b1;
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SRC = 1;
  localparam int IDLE_SNK = 2;
  localparam int IDLE_BOTH = 3;

  logic clk_i;
  logic rst_ni;
  lob_in_if in_if ();
  lob_out_if out_if ();

  limit_order_book_matcher_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  int head_q[2*PRICE_LEVELS];
  int tail_q[2*PRICE_LEVELS];
  int nxt_q[ORDER_IDS];
  int prv_q[ORDER_IDS];
  logic [QtyW-1:0] rqty[ORDER_IDS];
  int rprice[ORDER_IDS];
  logic rside[ORDER_IDS];
  bit live[ORDER_IDS];
  int bid_top;
  int ask_top;

  out_word_t trades_due[$];
  int errors;
  int idle_mode;
  bit hold_off;

  task automatic report(input string what, input out_word_t got, input out_word_t want);
    $display("MISMATCH %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic int lvl_of(input logic sd, input int pr);
    return (sd ? PRICE_LEVELS : 0) + pr;
  endfunction

  function automatic void book_unlink(input int lv, input int id);
    int p;
    int n;
    p = prv_q[id];
    n = nxt_q[id];
    if (p != NIL) nxt_q[p] = n; else head_q[lv] = n;
    if (n != NIL) prv_q[n] = p; else tail_q[lv] = p;
  endfunction

  function automatic void book_reset();
    foreach (head_q[i]) begin
      head_q[i] = NIL;
      tail_q[i] = NIL;
    end
    foreach (live[i]) live[i] = 1'b0;
    bid_top = 0;
    ask_top = PRICE_LEVELS;
  endfunction

  function automatic void book_apply(input in_word_t w);
    int id;
    int lv;
    int r;
    int nx;
    int t;
    logic [QtyW-1:0] q;
    logic [QtyW-1:0] f;
    out_word_t tw;
    int first;
    id = w.ord_id;
    first = trades_due.size();
    if (w.mode == MODE_CXL) begin
      if (live[id]) begin
        live[id] = 1'b0;
        book_unlink(lvl_of(rside[id], rprice[id]), id);
      end
      return;
    end
    if (w.limit_price == 0 || w.order_quantity == 0 || live[id]) return;
    q = w.order_quantity;
    while (q != 0 && (w.side == SIDE_BUY ?
           (ask_top <= w.limit_price && ask_top < PRICE_LEVELS) :
           (bid_top >= w.limit_price && bid_top > 0))) begin
      lv = (w.side == SIDE_BUY) ? lvl_of(SIDE_SELL, ask_top) : lvl_of(SIDE_BUY, bid_top);
      r = head_q[lv];
      while (r != NIL && q != 0) begin
        f = (q < rqty[r]) ? q : rqty[r];
        nx = nxt_q[r];
        tw.maker_id = IdW'(r);
        tw.taker_id = IdW'(id);
        tw.trade_price = PriceW'(rprice[r]);
        tw.trade_quantity = f;
        tw.last = 1'b0;
        trades_due.push_back(tw);
        q -= f;
        rqty[r] -= f;
        if (rqty[r] == 0) begin
          book_unlink(lv, r);
          live[r] = 1'b0;
        end
        r = nx;
      end
      if (head_q[lv] == NIL) begin
        if (w.side == SIDE_BUY) begin
          ask_top++;
          while (ask_top < PRICE_LEVELS && head_q[lvl_of(SIDE_SELL, ask_top)] == NIL)
            ask_top++;
        end else begin
          bid_top--;
          while (bid_top > 0 && head_q[lvl_of(SIDE_BUY, bid_top)] == NIL) bid_top--;
        end
      end
    end
    if (q != 0) begin
      lv = lvl_of(w.side, w.limit_price);
      t = tail_q[lv];
      if (w.side == SIDE_BUY) begin
        if (w.limit_price > bid_top) bid_top = w.limit_price;
      end else if (w.limit_price < ask_top) begin
        ask_top = w.limit_price;
      end
      rqty[id] = q;
      rprice[id] = w.limit_price;
      rside[id] = w.side;
      nxt_q[id] = NIL;
      if (t != NIL) begin
        nxt_q[t] = id;
        prv_q[id] = t;
      end else begin
        head_q[lv] = id;
        prv_q[id] = NIL;
      end
      tail_q[lv] = id;
      live[id] = 1'b1;
    end
    if (trades_due.size() > first) trades_due[$].last = 1'b1;
  endfunction

  function automatic bit roll(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  task automatic send_word(input in_word_t w);
    while ((idle_mode == IDLE_SRC || idle_mode == IDLE_BOTH) && roll(66)) @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.data = w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    book_apply(w);
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  function automatic in_word_t mk(input logic md, input int id, input logic sd,
                                  input int pr, input logic [QtyW-1:0] q);
    in_word_t w;
    w.mode = md;
    w.ord_id = IdW'(id);
    w.side = sd;
    w.limit_price = PriceW'(pr);
    w.order_quantity = q;
    return w;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int r;
    r = $urandom_range(99, 0);
    w.mode = (r < 22) ? MODE_CXL : MODE_ADD;
    w.ord_id = IdW'($urandom_range(ORDER_IDS - 1, 0));
    w.side = 1'($urandom_range(1, 0));
    w.limit_price = (r < 3) ? 8'd0 : (r < 8) ? PriceW'($urandom_range(255, 1)) :
                    PriceW'($urandom_range(136, 120));
    w.order_quantity = (r < 26 && r >= 22) ? 32'd0 : (r < 32) ? $urandom() :
                       $urandom_range(40, 1);
    return w;
  endfunction

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (trades_due.size() == 0) begin
        report("unexpected trade", out_if.data, '0);
      end else begin
        want = trades_due.pop_front();
        if (out_if.data.maker_id !== want.maker_id) report("maker_id", out_if.data, want);
        if (out_if.data.taker_id !== want.taker_id) report("taker_id", out_if.data, want);
        if (out_if.data.trade_price !== want.trade_price)
          report("trade_price", out_if.data, want);
        if (out_if.data.trade_quantity !== want.trade_quantity)
          report("trade_quantity", out_if.data, want);
        if (out_if.data.last !== want.last) report("last", out_if.data, want);
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off) out_if.ready <= 1'b0;
    else if (idle_mode == IDLE_SNK || idle_mode == IDLE_BOTH) out_if.ready <= !roll(66);
    else out_if.ready <= 1'b1;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  in_word_t plan[$];
  out_word_t typed[$];
  bit has_typed[$];

  task automatic wait_drained();
    int n;
    n = 0;
    while (trades_due.size() != 0) @(negedge clk_i);
    while (n < 40) begin
      @(negedge clk_i);
      n++;
    end
  endtask

  initial begin
    int n;
    in_word_t w;
    out_word_t tw;
    errors = 0;
    idle_mode = IDLE_NONE;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    book_reset();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table: rejects, cancels, extremes, FIFO and sweeps
    plan.push_back(mk(MODE_ADD, 0, SIDE_BUY, 0, 5));
    plan.push_back(mk(MODE_ADD, 0, SIDE_BUY, 10, 0));
    plan.push_back(mk(MODE_CXL, 7, SIDE_SELL, 255, 32'hffffffff));
    plan.push_back(mk(MODE_ADD, 1, SIDE_SELL, 255, 32'hffffffff));
    plan.push_back(mk(MODE_ADD, 1, SIDE_SELL, 100, 9));
    plan.push_back(mk(MODE_ADD, 2, SIDE_BUY, 255, 32'hffffffff));
    plan.push_back(mk(MODE_ADD, 63, SIDE_SELL, 1, 32'hffffffff));
    plan.push_back(mk(MODE_ADD, 3, SIDE_BUY, 1, 4));
    plan.push_back(mk(MODE_ADD, 4, SIDE_BUY, 1, 6));
    plan.push_back(mk(MODE_ADD, 5, SIDE_BUY, 2, 3));
    plan.push_back(mk(MODE_CXL, 5, SIDE_BUY, 0, 0));
    plan.push_back(mk(MODE_CXL, 5, SIDE_BUY, 0, 0));
    plan.push_back(mk(MODE_ADD, 6, SIDE_SELL, 1, 8));
    plan.push_back(mk(MODE_ADD, 7, SIDE_SELL, 50, 3));
    plan.push_back(mk(MODE_ADD, 8, SIDE_SELL, 50, 3));
    plan.push_back(mk(MODE_ADD, 9, SIDE_SELL, 60, 5));
    plan.push_back(mk(MODE_CXL, 8, SIDE_SELL, 0, 0));
    plan.push_back(mk(MODE_ADD, 10, SIDE_BUY, 254, 7));
    plan.push_back(mk(MODE_ADD, 11, SIDE_BUY, 254, 32'hffffffff));
    plan.push_back(mk(MODE_ADD, 12, SIDE_SELL, 1, 1));
    plan.push_back(mk(MODE_CXL, 63, SIDE_BUY, 0, 0));
    foreach (plan[i]) begin
      has_typed.push_back(1'b0);
      typed.push_back('0);
    end
    // the buy at the top tick takes the whole resting sell at 255
    tw.maker_id = 1; tw.taker_id = 2; tw.trade_price = 255;
    tw.trade_quantity = 32'hffffffff;
    tw.last = 1'b1;
    has_typed[5] = 1'b1;
    typed[5] = tw;

    foreach (plan[i]) begin
      n = trades_due.size();
      send_word(plan[i]);
      if (has_typed[i] && (trades_due.size() == n || trades_due[n] != typed[i]))
        report("directed row", trades_due.size() > n ? trades_due[n] : '0, typed[i]);
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = ph;
      for (int k = 0; k < 60; k++) send_word(rand_word());
      wait_drained();
    end

    // receiver held off while orders keep coming in
    idle_mode = IDLE_NONE;
    hold_off = 1'b1;
    fork
      begin
        n = 0;
        while (n < 400) begin
          @(negedge clk_i);
          n++;
        end
        hold_off = 1'b0;
      end
      for (int k = 0; k < 20; k++) begin
        w = rand_word();
        w.mode = MODE_ADD;
        send_word(w);
      end
    join
    wait_drained();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
